FILE: hw/rtl/wes_pkg.sv
package wes_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_UM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q16  = 3'd4;

  localparam logic [19:0] DEBOUNCE_RST  = 20'd1204;
  localparam logic [15:0] WINDOW_RST    = 16'd90;
  localparam logic [15:0] DIST_UM_RST   = 16'd4516;
  localparam logic [15:0] MIN_SPEED_RST = 16'd100;
  localparam logic [16:0] GAIN_Q16_RST  = 17'd60948;

  // Item operations
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] time_us;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] speed_mm_s;
    logic [6:0]  window_ticks;
    logic [15:0] burst_ticks;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_PR_RD,
    ST_PR_CHK,
    ST_ENDS,
    ST_NEW_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic edge_commit;
    logic prune_drop;
    logic latch_t0;
    logic rd_newest;
    logic latch_dt;
    logic mul1;
    logic mul2;
    logic speed_zero;
    logic div_start;
    logic take_quot;
    logic res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic edge_ok;
    logic ring_empty;
    logic stale;
    logic few;
    logic zero_res;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/wheel_encoder_speed_estimator_core.sv
// Wheel encoder speed estimator for one wheel. Each input beat is either an
// encoder edge or a speed query. An edge closer than the debounce register to
// the last accepted edge is dropped; otherwise its millisecond stamp goes into
// a ring of RING_DEPTH entries (oldest overwritten when full) and the 16-bit
// burst counter steps. A query prunes stamps older than the window register,
// then reports speed = gain * (n-1) * dist_per_tick_um / (newest - oldest) in
// mm/s, zero for fewer than two stamps, zero span, or an unscaled speed below
// min_speed_mm_s, saturated at 65535; it also returns and clears the burst
// count. An edge produces no output beat. A query prunes stale stamps one
// at a time through the ring RAM's single registered read port; with at
// least two stamps left it then multiplies and runs the bit-serial divider,
// whose quotient width is $clog2(RING_DEPTH+1) + 17 (24 at the default
// depth). One beat is worked on at a time; a finished result sits in the
// output register so the next beat is accepted while it waits. The user
// must write the registers only while the block is idle; the block itself
// does not enforce it.
module wheel_encoder_speed_estimator_core #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [wes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wes_pkg::in_item_t              in_data_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wes_pkg::out_item_t             out_data_o
);

  wes_pkg::cmd_t cmd;
  wes_pkg::sts_t sts;

  // sequencer: dispatch, prune loop, multiply, divide, result hand-off
  wes_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.operation),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // config registers, stamp ring, arithmetic and output register
  wes_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: hw/rtl/wes_ram.sv
module wes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wes_div.sv
module wes_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;
  logic            ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

`ifndef SYNTHESIS
  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not enter busy on start");

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q == CNTW'(1) |=> done_q)
    else $error("divider missed its last step");
`endif

endmodule

FILE: hw/rtl/wes_ctrl.sv
module wes_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  input  wes_pkg::sts_t sts_i,
  output wes_pkg::cmd_t cmd_o
);

  wes_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wes_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wes_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_op_i == wes_pkg::OP_EDGE) ? wes_pkg::ST_EDGE : wes_pkg::ST_PR_RD;
        end
      end
      wes_pkg::ST_EDGE: begin
        cmd_o.edge_commit = sts_i.edge_ok;
        state_d = wes_pkg::ST_IDLE;
      end
      wes_pkg::ST_PR_RD: begin
        // head entry address is on the RAM this cycle
        state_d = sts_i.ring_empty ? wes_pkg::ST_ENDS : wes_pkg::ST_PR_CHK;
      end
      wes_pkg::ST_PR_CHK: begin
        if (sts_i.stale) begin
          cmd_o.prune_drop = 1'b1;
          state_d = wes_pkg::ST_PR_RD;
        end else begin
          cmd_o.latch_t0 = 1'b1;
          state_d = wes_pkg::ST_ENDS;
        end
      end
      wes_pkg::ST_ENDS: begin
        if (sts_i.few) begin
          cmd_o.speed_zero = 1'b1;
          state_d = wes_pkg::ST_DONE;
        end else begin
          cmd_o.rd_newest = 1'b1;
          state_d = wes_pkg::ST_NEW_WAIT;
        end
      end
      wes_pkg::ST_NEW_WAIT: begin
        cmd_o.latch_dt = 1'b1;
        state_d = wes_pkg::ST_MUL1;
      end
      wes_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = wes_pkg::ST_MUL2;
      end
      wes_pkg::ST_MUL2: begin
        if (sts_i.zero_res) begin
          cmd_o.speed_zero = 1'b1;
          state_d = wes_pkg::ST_DONE;
        end else begin
          cmd_o.mul2 = 1'b1;
          state_d = wes_pkg::ST_DIV_GO;
        end
      end
      wes_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = wes_pkg::ST_DIV_WAIT;
      end
      wes_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_quot = 1'b1;
          state_d = wes_pkg::ST_DONE;
        end
      end
      wes_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = wes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wes_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == wes_pkg::ST_EDGE || state_q == wes_pkg::ST_PR_RD)
    else $error("accepted beat not dispatched");

  a_div_go_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wes_pkg::ST_DIV_GO |=> state_q == wes_pkg::ST_DIV_WAIT)
    else $error("divider start not followed by wait");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == wes_pkg::ST_IDLE)
    else $error("result load did not return to idle");
`endif

endmodule

FILE: hw/rtl/wes_dp.sv
module wes_dp #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wes_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wes_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wes_pkg::in_item_t                  in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output wes_pkg::out_item_t                 out_data_o,
  input  wes_pkg::cmd_t                      cmd_i,
  output wes_pkg::sts_t                      sts_o
);

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned P1W = CW + 16;       // (n-1) * dist
  localparam int unsigned P2W = CW + 33;       // (n-1) * dist * gain
  localparam int unsigned NW  = P2W - 16;      // dividend after dropping the Q16 bits
  localparam int unsigned HW  = (CW > 7) ? CW : 7;

  // configuration
  logic [19:0] debounce_q;
  logic [15:0] window_q;
  logic [15:0] dist_q;
  logic [15:0] min_q;
  logic [16:0] gain_q;

  // ring control and counters
  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [31:0]   last_q;
  logic [15:0]   burst_q;

  // item and work registers
  logic [31:0]    tus_q, tms_q;
  logic [31:0]    t0_q, dt_q;
  logic [P1W-1:0] prod1_q;
  logic [47:0]    mindt_q;
  logic [P2W-1:0] prod2_q;
  logic [15:0]    speed_q;

  logic               out_valid_q;
  wes_pkg::out_item_t out_q;

  logic [AW-1:0] head_inc;
  logic [AW:0]   wsum, nsum;
  logic [AW-1:0] tail_idx, newest_idx;
  logic [AW-1:0] waddr, raddr;
  logic          full;
  logic [CW-1:0] nm1;
  logic [31:0]   rdata;
  logic [31:0]   age;
  logic          div_done;
  logic [NW-1:0] quot;
  logic [HW-1:0] cnt_w;
  logic [6:0]    held;

  always_comb begin
    full     = count_q == CW'(RING_DEPTH);
    nm1      = count_q - CW'(1);
    head_inc = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
    // next free slot, count below depth here
    wsum     = {1'b0, head_q} + (AW+1)'(count_q);
    tail_idx = (wsum >= (AW+1)'(RING_DEPTH)) ? AW'(wsum - (AW+1)'(RING_DEPTH)) : wsum[AW-1:0];
    // newest entry, count at least one here
    nsum       = {1'b0, head_q} + (AW+1)'(nm1);
    newest_idx = (nsum >= (AW+1)'(RING_DEPTH)) ? AW'(nsum - (AW+1)'(RING_DEPTH))
                                                : nsum[AW-1:0];
    waddr = full ? head_q : tail_idx;
    raddr = cmd_i.rd_newest ? newest_idx : head_q;
    age   = tms_q - rdata;
    cnt_w = HW'(count_q);
    held  = (cnt_w > HW'(127)) ? 7'd127 : cnt_w[6:0];
  end

  wes_ram #(
    .WIDTH(32),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.edge_commit),
    .waddr_i(waddr),
    .wdata_i(tms_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  wes_div #(
    .NW(NW),
    .DW(32)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(prod2_q[P2W-1:16]),
    .divisor_i (dt_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= wes_pkg::DEBOUNCE_RST;
      window_q    <= wes_pkg::WINDOW_RST;
      dist_q      <= wes_pkg::DIST_UM_RST;
      min_q       <= wes_pkg::MIN_SPEED_RST;
      gain_q      <= wes_pkg::GAIN_Q16_RST;
      head_q      <= '0;
      count_q     <= '0;
      last_q      <= '0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wes_pkg::CFG_DEBOUNCE:  debounce_q <= cfg_data_i;
          wes_pkg::CFG_WINDOW:    window_q   <= cfg_data_i[15:0];
          wes_pkg::CFG_DIST_UM:   dist_q     <= cfg_data_i[15:0];
          wes_pkg::CFG_MIN_SPEED: min_q      <= cfg_data_i[15:0];
          wes_pkg::CFG_GAIN_Q16:  gain_q     <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (cmd_i.edge_commit) begin
        last_q  <= tus_q;
        burst_q <= burst_q + 16'd1;
        if (full) begin
          head_q <= head_inc;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end else if (cmd_i.prune_drop) begin
        head_q  <= head_inc;
        count_q <= nm1;
      end
      if (cmd_i.res_load) begin
        burst_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tus_q <= in_data_i.time_us;
      tms_q <= in_data_i.time_ms;
    end
    if (cmd_i.latch_t0) begin
      t0_q <= rdata;
    end
    if (cmd_i.latch_dt) begin
      dt_q <= rdata - t0_q;
    end
    if (cmd_i.mul1) begin
      prod1_q <= P1W'(nm1) * P1W'(dist_q);
      mindt_q <= 48'(min_q) * 48'(dt_q);
    end
    if (cmd_i.mul2) begin
      prod2_q <= P2W'(prod1_q) * P2W'(gain_q);
    end
    if (cmd_i.speed_zero) begin
      speed_q <= '0;
    end else if (cmd_i.take_quot) begin
      speed_q <= (|quot[NW-1:16]) ? 16'hFFFF : quot[15:0];
    end
    if (cmd_i.res_load) begin
      out_q.speed_mm_s   <= speed_q;
      out_q.window_ticks <= held;
      out_q.burst_ticks  <= burst_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.edge_ok    = (tus_q - last_q) >= 32'(debounce_q);
    sts_o.ring_empty = count_q == '0;
    sts_o.stale      = age > 32'(window_q);
    sts_o.few        = count_q < CW'(2);
    sts_o.zero_res   = (dt_q == '0) || (48'(prod1_q) < mindt_q);
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RING_DEPTH))
    else $error("ring count beyond depth");

  a_full_stays_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.edge_commit && full |=> count_q == CW'(RING_DEPTH))
    else $error("full ring lost an entry on write");

  a_drop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prune_drop |=> count_q == $past(count_q) - CW'(1))
    else $error("prune did not drop one entry");

  a_burst_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> burst_q == '0 && out_valid_q)
    else $error("query result did not clear burst count");
`endif

endmodule

FILE: verif/tb_wheel_encoder_speed_estimator_core.sv
`timescale 1ns / 1ps

module tb_wheel_encoder_speed_estimator_core;
  import wes_pkg::*;

  localparam int unsigned RING_DEPTH    = 64;
  localparam int unsigned NUM_REGS      = CFG_GAIN_Q16 + 1;
  // Longest query: 64 prunes, 24 divide steps and overhead.
  localparam int unsigned SETTLE_CYCLES = 300;
  // Covers about a thousand beats plus hold-offs.
  localparam longint unsigned RUN_LIMIT_NS = 64'd60_000_000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  wheel_encoder_speed_estimator_core #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the estimator: stamp ring, debounce and burst state, regs.
  // ---------------------------------------------------------------------------
  logic [31:0] stamp_mem [RING_DEPTH];
  int unsigned first_slot  = 0;  // oldest stamp
  int unsigned stamps_held = 0;
  logic [31:0] last_us     = '0;
  logic [15:0] edges_since_query = '0;

  logic [19:0] db_us      = DEBOUNCE_RST;
  logic [15:0] win_ms     = WINDOW_RST;
  logic [15:0] tick_um    = DIST_UM_RST;
  logic [15:0] floor_mm_s = MIN_SPEED_RST;
  logic [16:0] gain_q16   = GAIN_Q16_RST;

  // Speed readings still owed by the block, oldest first.
  out_item_t expected_readings [$];

  // Flow control knobs, percent per cycle.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;  // long receiver hold-off, counted down below
  int unsigned mismatches = 0;

  // Free running time base for well-formed stimulus.
  logic [31:0] sim_us  = '0;
  logic [31:0] sim_ms  = '0;
  int unsigned ms_frac = 0;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // Span-based speed: (n-1)*dist / dt in mm/s, floor-gated, Q16 gain, saturated.
  function automatic logic [15:0] estimate_speed();
    logic [31:0] t_old, t_new, span;
    logic [63:0] travel, quot;
    if (stamps_held < 2) return '0;
    t_old = stamp_mem[first_slot];
    t_new = stamp_mem[(first_slot + stamps_held - 1) % RING_DEPTH];
    span  = t_new - t_old;
    if (span == '0) return '0;
    travel = 64'(stamps_held - 1) * 64'(tick_um);
    // exact compare, no division
    if (travel < 64'(floor_mm_s) * 64'(span)) return '0;
    quot = (travel * 64'(gain_q16)) / ({32'd0, span} << 16);
    return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
  endfunction

  function automatic void record_item(input in_item_t it);
    out_item_t rd;
    if (it.operation == OP_EDGE) begin
      // debounce distance taken mod 2^32
      if ((it.time_us - last_us) >= 32'(db_us)) begin
        last_us = it.time_us;
        if (stamps_held < RING_DEPTH) begin
          stamp_mem[(first_slot + stamps_held) % RING_DEPTH] = it.time_ms;
          stamps_held++;
        end else begin
          stamp_mem[first_slot] = it.time_ms;
          first_slot = (first_slot + 1) % RING_DEPTH;
        end
        edges_since_query++;
      end
    end else begin
      while (stamps_held != 0 && (it.time_ms - stamp_mem[first_slot]) > 32'(win_ms)) begin
        first_slot = (first_slot + 1) % RING_DEPTH;
        stamps_held--;
      end
      rd.speed_mm_s   = estimate_speed();
      rd.window_ticks = 7'(stamps_held);
      rd.burst_ticks  = edges_since_query;
      edges_since_query = '0;
      expected_readings.push_back(rd);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus an optional long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result beat speed %0d window %0d burst %0d", $time,
                   out_data_o.speed_mm_s, out_data_o.window_ticks, out_data_o.burst_ticks);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (want.speed_mm_s !== out_data_o.speed_mm_s ||
            want.window_ticks !== out_data_o.window_ticks ||
            want.burst_ticks !== out_data_o.burst_ticks) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp/got speed %0d/%0d window %0d/%0d burst %0d/%0d",
                     $time, want.speed_mm_s, out_data_o.speed_mm_s, want.window_ticks,
                     out_data_o.window_ticks, want.burst_ticks, out_data_o.burst_ticks);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Valid stays up across back-to-back beats; it only drops in a
  // gap or when a caller pauses, so it never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    record_item(it);
  endtask

  task automatic send_op(input logic op, input logic [31:0] tus, input logic [31:0] tms);
    in_item_t it;
    it.operation = op;
    it.time_us   = tus;
    it.time_ms   = tms;
    send_item(it);
  endtask

  task automatic pause_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a trailing edge beat or query finish before touching regs.
  task automatic settle();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE:  db_us      = val[19:0];
      CFG_WINDOW:    win_ms     = val[15:0];
      CFG_DIST_UM:   tick_um    = val[15:0];
      CFG_MIN_SPEED: floor_mm_s = val[15:0];
      CFG_GAIN_Q16:  gain_q16   = val[16:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [19:0] dbv, input logic [19:0] winv,
                           input logic [19:0] distv, input logic [19:0] minv,
                           input logic [19:0] gainv);
    write_reg(CFG_DEBOUNCE, dbv);
    write_reg(CFG_WINDOW, winv);
    write_reg(CFG_DIST_UM, distv);
    write_reg(CFG_MIN_SPEED, minv);
    write_reg(CFG_GAIN_Q16, gainv);
  endtask

  // Upper junk bits on the narrow regs exercise masking.
  task automatic load_random_regs();
    load_regs(20'($urandom_range(0, 3000)),
              20'($urandom_range(20, 400) | ($urandom_range(15) << 16)),
              20'($urandom_range(1, 65535) | ($urandom_range(15) << 16)),
              20'($urandom_range(0, 3000) | ($urandom_range(15) << 16)),
              20'($urandom_range(0, 131071) | ($urandom_range(7) << 17)));
  endtask

  // Mostly a plausible edge train on a moving clock; some beats are raw noise.
  task automatic next_item(input int unsigned query_pct, output in_item_t it);
    int unsigned roll;
    int unsigned step_us;
    roll = $urandom_range(99);
    if (roll < 12) begin
      it.operation = ($urandom_range(1) == 0) ? OP_EDGE : OP_QUERY;
      it.time_us   = $urandom;
      it.time_ms   = $urandom;
    end else begin
      // occasional jump so a query has stale stamps to drop
      if (roll < 16) sim_ms = sim_ms + $urandom_range(0, 32'(win_ms) * 2 + 2);
      case ($urandom_range(3))
        0:       step_us = $urandom_range(0, 32'(db_us));
        1, 2:    step_us = 32'(db_us) + $urandom_range(0, 32'(db_us) / 2 + 50);
        default: step_us = $urandom_range(0, 4000);
      endcase
      sim_us  = sim_us + step_us;
      ms_frac = ms_frac + step_us;
      sim_ms  = sim_ms + ms_frac / 1000;
      ms_frac = ms_frac % 1000;
      it.operation = ($urandom_range(99) < query_pct) ? OP_QUERY : OP_EDGE;
      it.time_us   = sim_us;
      it.time_ms   = sim_ms;
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle,
                            input int unsigned stall, input int unsigned query_pct);
    in_item_t it;
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned k = 0; k < count; k++) begin
      next_item(query_pct, it);
      send_item(it);
      if ($urandom_range(199) == 0) pause_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: debounce 1204 us, window 90 ms.
  task automatic test_directed_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    send_op(OP_QUERY, 32'd0, 32'd0);         // empty ring, zero burst
    send_op(OP_EDGE, 32'd0, 32'd5);          // too close to reset value of last edge
    send_op(OP_EDGE, 32'd1203, 32'd6);       // one short of debounce
    send_op(OP_EDGE, 32'd1204, 32'd1000);    // exactly on debounce
    send_op(OP_EDGE, 32'd2407, 32'd1001);    // bounce
    send_op(OP_QUERY, 32'd2500, 32'd1001);   // single stamp
    send_op(OP_EDGE, 32'd2408, 32'd1000);
    send_op(OP_QUERY, 32'd2500, 32'd1000);   // two stamps, zero span
    send_op(OP_EDGE, 32'd4000, 32'd1010);
    send_op(OP_EDGE, 32'd6000, 32'd1020);
    send_op(OP_EDGE, 32'd8000, 32'd1040);
    send_op(OP_QUERY, 32'd8100, 32'd1090);   // age == window: kept
    send_op(OP_QUERY, 32'd8200, 32'd1091);   // age window+1: dropped
    send_op(OP_QUERY, 32'd8300, 32'd1200);   // everything stale
    send_op(OP_EDGE, 32'd10000, 32'd1200);
    send_op(OP_EDGE, 32'd12000, 32'd1290);
    send_op(OP_QUERY, 32'd12100, 32'd1290);  // 50 mm/s, under the floor
    send_op(OP_EDGE, 32'hFFFF_FB00, 32'hFFFF_FFF0);
    send_op(OP_EDGE, 32'h0000_0200, 32'h0000_0010);  // both clocks wrapped
    send_op(OP_QUERY, 32'h0000_0400, 32'h0000_0020);
    send_op(OP_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_register_extremes();
    sim_us = $urandom;
    sim_ms = $urandom;
    // no debounce, widest window, max distance and gain: saturation
    load_regs(20'd0, 20'h0FFFF, 20'h0FFFF, 20'd0, 20'h1FFFF);
    send_op(OP_EDGE, 32'd100, 32'h0000_1000);
    send_op(OP_EDGE, 32'd101, 32'h0000_1001);
    send_op(OP_EDGE, 32'd102, 32'h0000_1002);
    send_op(OP_QUERY, 32'd103, 32'h0000_1002);
    run_random(100, 0, 0, 15);
    settle();
    // debounce of 1000000 us, window zero via masked write, top floor, gain zero
    load_regs(20'd1_000_000, 20'h10000, 20'd1, 20'h0FFFF, 20'd0);
    run_random(60, 13, 13, 20);
    settle();
    // distance zero via masked write; unused indexes must not land anywhere
    load_regs(20'($urandom_range(0, 2000)), 20'd1000, 20'hF0000, 20'd0, 20'h10000);
    for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 20'($urandom));
    run_random(80, 0, 0, 20);
    settle();
  endtask

  task automatic test_idle_mix();
    // start both clocks just shy of their wrap
    sim_us = 32'hFFFF_FFFF - $urandom_range(0, 2_000_000);
    sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
    load_random_regs();
    run_random(155, 0, 0, 15);
    settle();
    load_regs(20'd500, 20'd200, 20'd4516, 20'd0, 20'd0);  // gain zero, reachable
    run_random(155, 49, 0, 15);
    settle();
    load_random_regs();
    run_random(155, 0, 49, 15);
    settle();
    load_regs(20'($urandom_range(0, 2000)), 20'd1, 20'($urandom_range(1, 65535)),
              20'($urandom_range(0, 3000)), 20'($urandom_range(0, 131071)));
    run_random(155, 13, 13, 15);
    settle();
  endtask

  // Long receiver hold-off fills the result register and backs up the input;
  // then the sender waits for every result before going on.
  task automatic test_flow_control();
    load_random_regs();
    hold_left = 3000;
    run_random(60, 0, 0, 60);
    pause_for_results();
    run_random(40, 49, 49, 30);
    settle();
  endtask

  // More accepted edges than the ring holds: the oldest stamps get overwritten.
  task automatic test_ring_wrap();
    in_item_t it;
    load_regs(20'd0, 20'h0FFFF, 20'd4516, 20'd100, 20'd60948);
    idle_pct  = 0;
    stall_pct = 0;
    it.operation = OP_EDGE;
    for (int unsigned k = 0; k < RING_DEPTH + 6; k++) begin
      it.time_us = sim_us + 32'(k);
      it.time_ms = sim_ms + 32'(k / 4);
      send_item(it);
    end
    send_op(OP_QUERY, sim_us + 32'h2_0000, sim_ms + 32'd20);
    settle();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_register_extremes();
    test_idle_mix();
    test_flow_control();
    test_ring_wrap();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/wes_pkg.sv
hw/rtl/wes_ram.sv
hw/rtl/wes_div.sv
hw/rtl/wes_ctrl.sv
hw/rtl/wes_dp.sv
hw/rtl/wheel_encoder_speed_estimator_core.sv
verif/tb_wheel_encoder_speed_estimator_core.sv
